### rtl/core/nrp_pkg.sv
// nrp_pkg: types and constants shared by the nat-pmp reply parser modules
`timescale 1ns / 1ps

package nrp_pkg;

   localparam int STORE_DEPTH    = 16;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [4:0] MIN_HEADER    = 5'd8;
   localparam logic [4:0] MIN_ADDR_BODY = 5'd12;
   localparam logic [4:0] MIN_MAP_BODY  = 5'd16;

   localparam logic [7:0] OP_ADDRESS = 8'd128;
   localparam logic [7:0] OP_MAPPING = 8'd129;

   localparam logic [3:0] ST_OK           = 4'd0;
   localparam logic [3:0] ST_SHORT        = 4'd1;
   localparam logic [3:0] ST_VERSION      = 4'd2;
   localparam logic [3:0] ST_OPCODE       = 4'd3;
   localparam logic [3:0] ST_REFUSE_SHIFT = 4'd2;
   localparam logic [3:0] ST_REFUSE_OTHER = 4'd8;
   localparam logic [3:0] ST_BODY_SHORT   = 4'd9;
   localparam logic [3:0] ST_PORT_ZERO    = 4'd10;

   // one complete datagram as handed from the front to the back
   typedef struct packed {
      logic [STORE_DEPTH-1:0][7:0] bytes;
      logic [4:0]                  size;
      logic                        mapping;
   } rec_type;

endpackage

### rtl/core/nrp_front.sv
// nrp_front: takes reply beats, keeps the first sixteen bytes and emits a datagram record
`timescale 1ns / 1ps

module nrp_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_reply_byte,
   input  logic             req_last_byte,
   input  logic             req_expect_mapping,
   input  logic             q_full,
   output logic             q_push,
   output nrp_pkg::rec_type q_data
);

   logic [4:0]                           count_ff;
   logic [4:0]                           count_in;
   logic [nrp_pkg::STORE_DEPTH-1:0][7:0] store_ff;
   logic                                 accept;
   logic                                 room;

   assign req_stall = q_full;
   assign accept    = req_valid & ~req_stall;
   assign room      = ~count_ff[4];
   assign q_push    = accept & req_last_byte;

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         if (req_last_byte) begin
            count_in = '0;
         end else if (room) begin
            count_in = count_ff + 5'd1;
         end
      end
   end

   // current beat merged in at its slot
   always_comb begin
      for (int i = 0; i < nrp_pkg::STORE_DEPTH; i++) begin
         if (room && (count_ff[3:0] == 4'(i))) begin
            q_data.bytes[i] = req_reply_byte;
         end else begin
            q_data.bytes[i] = store_ff[i];
         end
      end
      q_data.size    = room ? (count_ff + 5'd1) : count_ff;
      q_data.mapping = req_expect_mapping;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && room) begin
         store_ff[count_ff[3:0]] <= req_reply_byte;
      end
   end

endmodule

### rtl/core/nrp_queue.sv
// nrp_queue: short first-in first-out queue of datagram records between front and back
`timescale 1ns / 1ps

module nrp_queue #(
   parameter int Depth = nrp_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  nrp_pkg::rec_type push_data,
   input  logic             pop,
   output nrp_pkg::rec_type head,
   output logic             full,
   output logic             empty
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   nrp_pkg::rec_type entries_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff;
   logic [PtrW-1:0]  wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff;
   logic [PtrW-1:0]  rd_ptr_in;
   logic [CntW-1:0]  count_ff;
   logic [CntW-1:0]  count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CntW'(Depth));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign head    = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/core/nrp_back.sv
// nrp_back: checks one datagram record and holds the result beat in the output register
`timescale 1ns / 1ps

module nrp_back (
   input  logic             clock,
   input  logic             reset,
   input  nrp_pkg::rec_type head,
   input  logic             q_empty,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [3:0]       rsp_status,
   output logic [15:0]      rsp_result_code,
   output logic [31:0]      rsp_external_address,
   output logic [15:0]      rsp_external_port,
   output logic [31:0]      rsp_lease_seconds
);

   logic        valid_ff;
   logic        valid_in;
   logic [3:0]  status_ff;
   logic [3:0]  status_in;
   logic [15:0] code_ff;
   logic [15:0] code_in;
   logic [31:0] addr_ff;
   logic [31:0] addr_in;
   logic [15:0] port_ff;
   logic [15:0] port_in;
   logic [31:0] lease_ff;
   logic [31:0] lease_in;
   logic [15:0] code;
   logic [15:0] port;
   logic [7:0]  want_op;

   assign q_pop    = ~q_empty & (~valid_ff | ~rsp_stall);
   assign valid_in = q_pop | (valid_ff & rsp_stall);

   assign code    = {head.bytes[2], head.bytes[3]};
   assign port    = {head.bytes[10], head.bytes[11]};
   assign want_op = head.mapping ? nrp_pkg::OP_MAPPING : nrp_pkg::OP_ADDRESS;

   always_comb begin
      status_in = nrp_pkg::ST_OK;
      code_in   = '0;
      addr_in   = '0;
      port_in   = '0;
      lease_in  = '0;
      if (head.size < nrp_pkg::MIN_HEADER) begin
         status_in = nrp_pkg::ST_SHORT;
      end else begin
         code_in = code;
         if (head.bytes[0] != 8'd0) begin
            status_in = nrp_pkg::ST_VERSION;
         end else if (head.bytes[1] != want_op) begin
            status_in = nrp_pkg::ST_OPCODE;
         end else if (code != 16'd0) begin
            if (code inside {[16'd2:16'd5]}) begin
               status_in = code[3:0] + nrp_pkg::ST_REFUSE_SHIFT;
            end else begin
               status_in = nrp_pkg::ST_REFUSE_OTHER;
            end
         end else if (!head.mapping) begin
            if (head.size < nrp_pkg::MIN_ADDR_BODY) begin
               status_in = nrp_pkg::ST_BODY_SHORT;
            end else begin
               addr_in = {head.bytes[8], head.bytes[9], head.bytes[10], head.bytes[11]};
            end
         end else begin
            if (head.size < nrp_pkg::MIN_MAP_BODY) begin
               status_in = nrp_pkg::ST_BODY_SHORT;
            end else begin
               port_in   = port;
               lease_in  = {head.bytes[12], head.bytes[13], head.bytes[14], head.bytes[15]};
               status_in = (port == 16'd0) ? nrp_pkg::ST_PORT_ZERO : nrp_pkg::ST_OK;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         status_ff <= status_in;
         code_ff   <= code_in;
         addr_ff   <= addr_in;
         port_ff   <= port_in;
         lease_ff  <= lease_in;
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_status           = status_ff;
   assign rsp_result_code      = code_ff;
   assign rsp_external_address = addr_ff;
   assign rsp_external_port    = port_ff;
   assign rsp_lease_seconds    = lease_ff;

endmodule

### rtl/core/natpmp_reply_parser_core.sv
// natpmp_reply_parser_core: top level of the nat-pmp reply parser
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  reply_byte, last_byte, expect_mapping
//   rsp      out        rsp_valid / rsp_stall  status, result_code, external_address,
//                                              external_port, lease_seconds
//
// one request beat is taken every cycle while req_stall is low; a reply's result beat
// is registered first in the record queue and then in the output register before it shows on rsp
// reset clears the byte count, the queue pointers and rsp_valid; no clearing pass
// rsp_stall holds the output register, then up to QUEUE_DEPTH finished replies queue up,
// and only when the queue is full does req_stall rise
`timescale 1ns / 1ps

module natpmp_reply_parser_core #(
   parameter int QUEUE_DEPTH = nrp_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_reply_byte,
   input  logic        req_last_byte,
   input  logic        req_expect_mapping,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_status,
   output logic [15:0] rsp_result_code,
   output logic [31:0] rsp_external_address,
   output logic [15:0] rsp_external_port,
   output logic [31:0] rsp_lease_seconds
);

   nrp_pkg::rec_type push_data;
   nrp_pkg::rec_type head;
   logic             q_push;
   logic             q_pop;
   logic             q_full;
   logic             q_empty;

   nrp_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_reply_byte     (req_reply_byte),
      .req_last_byte      (req_last_byte),
      .req_expect_mapping (req_expect_mapping),
      .q_full             (q_full),
      .q_push             (q_push),
      .q_data             (push_data)
   );

   nrp_queue #(
      .Depth (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .pop       (q_pop),
      .head      (head),
      .full      (q_full),
      .empty     (q_empty)
   );

   nrp_back u_back (
      .clock                (clock),
      .reset                (reset),
      .head                 (head),
      .q_empty              (q_empty),
      .q_pop                (q_pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_result_code      (rsp_result_code),
      .rsp_external_address (rsp_external_address),
      .rsp_external_port    (rsp_external_port),
      .rsp_lease_seconds    (rsp_lease_seconds)
   );

endmodule

### tb/natpmp_reply_parser_core_test.sv
// natpmp_reply_parser_core_test: self-checking regression of the nat-pmp reply parser core
`timescale 1ns / 1ps

module natpmp_reply_parser_core_test;

   localparam int CYCLE_LIMIT = 200000;
   localparam int TAIL_CYCLES = 10;
   localparam int MAX_LEN     = 24;

   typedef struct packed {
      logic [3:0]  status;
      logic [15:0] result_code;
      logic [31:0] external_address;
      logic [15:0] external_port;
      logic [31:0] lease_seconds;
   } reply_fields_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_reply_byte;
   logic        req_last_byte;
   logic        req_expect_mapping;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [3:0]  rsp_status;
   logic [15:0] rsp_result_code;
   logic [31:0] rsp_external_address;
   logic [15:0] rsp_external_port;
   logic [31:0] rsp_lease_seconds;

   // parser state as the block should hold it
   logic [7:0]       held_bytes [nrp_pkg::STORE_DEPTH];
   logic [4:0]       held_count = 5'd0;
   reply_fields_type expected_replies [$];
   reply_fields_type want_reply;

   logic [7:0] dgram [MAX_LEN];
   bit         idle_bursts = 1'b1;
   int         errors = 0;
   int         cycle_count = 0;
   int         bytes_sent = 0;
   int         datagrams_sent = 0;
   int         results_checked = 0;
   int         status_seen [16];

   natpmp_reply_parser_core DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_reply_byte       (req_reply_byte),
      .req_last_byte        (req_last_byte),
      .req_expect_mapping   (req_expect_mapping),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_result_code      (rsp_result_code),
      .rsp_external_address (rsp_external_address),
      .rsp_external_port    (rsp_external_port),
      .rsp_lease_seconds    (rsp_lease_seconds)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timed out after %0d cycles", $time, cycle_count);
         $display("natpmp_reply_parser_core regression: fail");
         $finish;
      end
   end

   // expected result of one accepted byte beat
   task automatic parse_reply_byte(input logic [7:0] b, input logic last, input logic mapping);
      reply_fields_type r;
      logic [15:0]      code;
      logic [4:0]       size;
      if (held_count < nrp_pkg::STORE_DEPTH) begin
         held_bytes[held_count[3:0]] = b;
         held_count++;
      end
      bytes_sent++;
      if (!last) return;
      size = held_count;
      held_count = 5'd0;
      r = '0;
      if (size < nrp_pkg::MIN_HEADER) begin
         r.status = nrp_pkg::ST_SHORT;
      end else begin
         code = {held_bytes[2], held_bytes[3]};
         r.result_code = code;
         if (held_bytes[0] != 8'd0) begin
            r.status = nrp_pkg::ST_VERSION;
         end else if (held_bytes[1] != (mapping ? nrp_pkg::OP_MAPPING
                                                : nrp_pkg::OP_ADDRESS)) begin
            r.status = nrp_pkg::ST_OPCODE;
         end else if (code != 16'd0) begin
            r.status = (code >= 16'd2 && code <= 16'd5)
                       ? code[3:0] + nrp_pkg::ST_REFUSE_SHIFT
                       : nrp_pkg::ST_REFUSE_OTHER;
         end else if (!mapping) begin
            if (size < nrp_pkg::MIN_ADDR_BODY) begin
               r.status = nrp_pkg::ST_BODY_SHORT;
            end else begin
               r.status = nrp_pkg::ST_OK;
               r.external_address = {held_bytes[8], held_bytes[9],
                                     held_bytes[10], held_bytes[11]};
            end
         end else if (size < nrp_pkg::MIN_MAP_BODY) begin
            r.status = nrp_pkg::ST_BODY_SHORT;
         end else begin
            r.external_port = {held_bytes[10], held_bytes[11]};
            r.lease_seconds = {held_bytes[12], held_bytes[13], held_bytes[14], held_bytes[15]};
            r.status = (r.external_port == 16'd0) ? nrp_pkg::ST_PORT_ZERO : nrp_pkg::ST_OK;
         end
      end
      expected_replies.insert(expected_replies.size(), r);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_replies.size() == 0) begin
            errors++;
            $display("%0t: status expected none actual %0d (unexpected result beat)",
                     $time, rsp_status);
         end else begin
            want_reply = expected_replies.pop_front();
            compare_field("status", 32'(want_reply.status), 32'(rsp_status));
            compare_field("result_code", 32'(want_reply.result_code),
                          32'(rsp_result_code));
            compare_field("external_address", want_reply.external_address,
                          rsp_external_address);
            compare_field("external_port", 32'(want_reply.external_port),
                          32'(rsp_external_port));
            compare_field("lease_seconds", want_reply.lease_seconds, rsp_lease_seconds);
            status_seen[want_reply.status]++;
            results_checked++;
         end
      end
   end

   // receiver back-pressure in bursts
   initial begin
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_bursts && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 9);
            rsp_stall = 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last, input logic mapping);
      int gap;
      @(negedge clock);
      if (idle_bursts && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 9);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_reply_byte     = b;
      req_last_byte      = last;
      req_expect_mapping = mapping;
      req_valid          = 1'b1;
      do @(posedge clock); while (req_stall);
      parse_reply_byte(b, last, mapping);
   endtask

   // expect_mapping only matters on the last beat, so it is random elsewhere
   task automatic send_datagram(input int len, input logic mapping);
      for (int i = 0; i < len; i++) begin
         send_byte(dgram[i], i == len - 1, (i == len - 1) ? mapping : 1'($urandom_range(0, 1)));
      end
      datagrams_sent++;
   endtask

   task automatic fill_reply(input logic mapping, input logic [15:0] code,
                             input logic [15:0] port, input logic [31:0] word);
      for (int i = 0; i < MAX_LEN; i++) dgram[i] = 8'($urandom);
      dgram[0] = 8'd0;
      dgram[1] = mapping ? nrp_pkg::OP_MAPPING : nrp_pkg::OP_ADDRESS;
      dgram[2] = code[15:8];
      dgram[3] = code[7:0];
      if (mapping) begin
         dgram[10] = port[15:8];
         dgram[11] = port[7:0];
         {dgram[12], dgram[13], dgram[14], dgram[15]} = word;
      end else begin
         {dgram[8], dgram[9], dgram[10], dgram[11]} = word;
      end
   endtask

   task automatic drain_results();
      while (expected_replies.size() != 0) @(posedge clock);
   endtask

   task automatic test_short_replies();
      fill_reply(1'b0, 16'd0, 16'd1, 32'd1);
      dgram[0] = 8'hFF;
      send_datagram(1, 1'b0);
      dgram[0] = 8'h00;
      send_datagram(1, 1'b1);
      fill_reply(1'b1, 16'd0, 16'd1, 32'd1);
      send_datagram(7, 1'b1);
   endtask

   task automatic test_header_checks();
      fill_reply(1'b0, 16'd0, 16'd1, 32'd1);
      dgram[0] = 8'hFF;
      send_datagram(8, 1'b0);
      dgram[0] = 8'h01;
      send_datagram(12, 1'b0);
      fill_reply(1'b0, 16'd0, 16'd1, 32'd1);
      send_datagram(16, 1'b1);
      fill_reply(1'b1, 16'd0, 16'd1, 32'd1);
      send_datagram(12, 1'b0);
      dgram[1] = 8'hFF;
      send_datagram(16, 1'b1);
   endtask

   task automatic test_refusal_codes();
      logic [15:0] codes [7] = '{16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'hFFFF};
      for (int i = 0; i < 7; i++) begin
         fill_reply(1'(i % 2), codes[i], 16'd1, 32'd1);
         send_datagram(8 + 8 * (i % 2), 1'(i % 2));
      end
   endtask

   task automatic test_body_lengths();
      fill_reply(1'b0, 16'd0, 16'd0, 32'hFFFF_FFFF);
      send_datagram(8, 1'b0);
      send_datagram(11, 1'b0);
      send_datagram(12, 1'b0);
      fill_reply(1'b0, 16'd0, 16'd0, 32'd0);
      send_datagram(12, 1'b0);
      fill_reply(1'b1, 16'd0, 16'hFFFF, 32'hFFFF_FFFF);
      send_datagram(15, 1'b1);
      send_datagram(16, 1'b1);
      fill_reply(1'b1, 16'd0, 16'd0, 32'h1234_5678);
      send_datagram(16, 1'b1);
   endtask

   task automatic test_long_replies();
      fill_reply(1'b0, 16'd0, 16'd0, 32'h8000_0001);
      send_datagram(MAX_LEN, 1'b0);
      fill_reply(1'b1, 16'd0, 16'd1, 32'd0);
      send_datagram(17, 1'b1);
      send_datagram(MAX_LEN, 1'b1);
   endtask

   // one random datagram: mostly well formed, some noise, broken headers and truncation
   task automatic send_random_reply();
      logic        mapping;
      logic [15:0] code;
      logic [15:0] port;
      int          full;
      int          len;
      int          kind;
      mapping = 1'($urandom_range(0, 1));
      code    = ($urandom_range(0, 3) != 0) ? 16'd0 :
                ($urandom_range(0, 1) != 0) ? 16'($urandom_range(1, 6)) : 16'($urandom);
      port    = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom);
      fill_reply(mapping, code, port, $urandom);
      full = mapping ? 16 : 12;
      len  = ($urandom_range(0, 3) == 0) ? $urandom_range(full, MAX_LEN) : full;
      kind = $urandom_range(0, 9);
      if (kind == 7) begin
         for (int i = 0; i < MAX_LEN; i++) dgram[i] = 8'($urandom);
         len = $urandom_range(1, MAX_LEN);
      end else if (kind == 8) begin
         if ($urandom_range(0, 1) != 0) dgram[0] = 8'($urandom_range(1, 255));
         else mapping = !mapping;
      end else if (kind == 9) begin
         len = $urandom_range(1, full - 1);
      end
      send_datagram(len, mapping);
   endtask

   task automatic test_random_replies();
      int first_byte;
      int first_dgram;
      first_byte  = bytes_sent;
      first_dgram = datagrams_sent;
      while (bytes_sent - first_byte < 160 || datagrams_sent - first_dgram < 12) begin
         // alternate stretches with and without idling
         if ((datagrams_sent - first_dgram) % 5 == 0) idle_bursts = !idle_bursts;
         send_random_reply();
      end
      idle_bursts = 1'b1;
   endtask

   // a run of single-beat replies can fill the record queue under back-pressure, then the sender waits
   task automatic test_pause_until_drained();
      for (int i = 0; i < 8; i++) begin
         dgram[0] = 8'($urandom);
         send_datagram(1, 1'($urandom_range(0, 1)));
      end
      @(negedge clock);
      req_valid = 1'b0;
      drain_results();
      for (int i = 0; i < 3; i++) send_random_reply();
   endtask

   task automatic test_quiet_tail();
      idle_bursts = 1'b0;
      for (int i = 0; i < 4; i++) send_random_reply();
   endtask

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_reply_byte     = 8'd0;
      req_last_byte      = 1'b0;
      req_expect_mapping = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_short_replies();
      test_header_checks();
      test_refusal_codes();
      test_body_lengths();
      test_long_replies();
      test_random_replies();
      test_pause_until_drained();
      test_quiet_tail();

      @(negedge clock);
      req_valid = 1'b0;
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d datagrams in %0d byte beats, %0d results checked",
               datagrams_sent, bytes_sent, results_checked);
      $write("status mix: ok %0d short %0d version %0d opcode %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      $display(" refusal %0d body short %0d port zero %0d",
               status_seen[4] + status_seen[5] + status_seen[6] + status_seen[7] + status_seen[8],
               status_seen[9], status_seen[10]);
      if (errors == 0) begin
         $display("natpmp_reply_parser_core regression: pass");
      end else begin
         $display("natpmp_reply_parser_core regression: fail");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/nrp_pkg.sv
rtl/core/nrp_front.sv
rtl/core/nrp_queue.sv
rtl/core/nrp_back.sv
rtl/core/natpmp_reply_parser_core.sv
tb/natpmp_reply_parser_core_test.sv
